### rtl/gmc_pkg.sv
// Shared types and constants for the Gilbert-Moore code builder.
package gmc_pkg;

    localparam int COUNT_BITS = 24;
    localparam int SYM_W      = 8;
    localparam int LEN_W      = 5;
    localparam int CODE_W     = 25;
    // wide enough for any code length over the whole count width range
    localparam int LEN_MAX_W  = 6;

    typedef struct packed {
        logic [SYM_W-1:0]      symbol;
        logic [COUNT_BITS-1:0] count;
        logic                  last;
    } t_gmc_in;

    typedef struct packed {
        logic [SYM_W-1:0]  symbol_out;
        logic [LEN_W-1:0]  code_length;
        logic [CODE_W-1:0] code_bits;
        logic              over_total;
        logic              last_out;
    } t_gmc_out;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic exp_step;
        logic out_load;
    } t_gmc_cmd;

    typedef struct packed {
        logic [LEN_MAX_W-1:0] len;
        logic                 out_busy;
    } t_gmc_sts;

endpackage

### rtl/gilbert_moore_code_builder_unit.sv
// Gilbert-Moore code builder: one code word per input beat.
// Per item of code length L (N = COUNT_BITS): the accept cycle, N + 3 remainder
// steps of the long divider, L expansion steps, one output load; the length
// search overlaps the remainder. The next item is accepted after the output load.
// The output load registers the result and sets it valid; a held result delays the load.
// Synchronous active-low reset: total_count = 1, running sum 0, no result.
module gilbert_moore_code_builder_unit import gmc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [COUNT_BITS-1:0] i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_gmc_in               i_in,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_gmc_out              o_data
);

    t_gmc_cmd cmd;
    t_gmc_sts sts;

    gmc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    gmc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_data      (o_data)
    );

endmodule

### rtl/gmc_datapath.sv
// Datapath: running sum, length search, long division and output register.
module gmc_datapath import gmc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [COUNT_BITS-1:0] i_cfg_wdata,
    input  t_gmc_in               i_in,
    input  t_gmc_cmd              i_cmd,
    output t_gmc_sts              o_sts,
    input  logic                  i_stall,
    output logic                  o_valid,
    output t_gmc_out              o_data
);

    localparam int N  = COUNT_BITS;
    localparam int NW = N + 3;            // numerator 2C + c
    localparam int RW = N + 2;            // shifted remainder
    localparam int LW = $clog2(N + 2);    // code length up to N + 1

    logic [N-1:0]      r_total;
    logic [N:0]        r_cum;
    logic [NW-1:0]     r_num;
    logic [N:0]        r_den;
    logic [RW-1:0]     r_rem;
    logic [N:0]        r_s;
    logic [N-1:0]      r_t;
    logic [LW-1:0]     r_k;
    logic              r_ls_done;
    logic [CODE_W-1:0] r_bits;
    logic [SYM_W-1:0]  r_sym;
    logic              r_last;
    logic              r_over;
    logic              r_valid;
    t_gmc_out          r_out;

    logic [N-1:0]  t_eff;
    logic [N+1:0]  sum;
    logic          over_c;
    logic [N:0]    cum_sat;
    logic [NW-1:0] num_c;
    logic [RW-1:0] rem_sh;
    logic          ge;
    logic [RW-1:0] rem_nx;
    logic          ls_hit;
    logic [LW-1:0] len;
    logic          n_valid;

    always_comb begin
        t_eff   = (r_total == '0) ? N'(1) : r_total;
        sum     = (N+2)'(r_cum) + (N+2)'(i_in.count);
        over_c  = sum > (N+2)'(t_eff);
        cum_sat = sum[N+1] ? '1 : sum[N:0];
        num_c   = NW'({r_cum, 1'b0}) + NW'(i_in.count);
        // numerator bits enter MSB first, then zeros for the expansion
        if (i_cmd.mod_step) begin
            rem_sh = {r_rem[RW-2:0], r_num[NW-1]};
        end else begin
            rem_sh = {r_rem[RW-2:0], 1'b0};
        end
        ge      = rem_sh >= RW'(r_den);
        rem_nx  = ge ? (rem_sh - RW'(r_den)) : rem_sh;
        ls_hit  = (r_k == LW'(N)) || (r_s >= (N+1)'(r_t));
        len     = LW'(r_k + 1'b1);
        n_valid = i_cmd.out_load | (r_valid & i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= N'(1);
            r_cum     <= '0;
            r_valid   <= 1'b0;
            r_ls_done <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_total <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_cum     <= i_in.last ? '0 : cum_sat;
                r_ls_done <= 1'b0;
            end else if (i_cmd.mod_step && !r_ls_done && ls_hit) begin
                r_ls_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num  <= num_c;
            r_den  <= {t_eff, 1'b0};
            r_rem  <= '0;
            r_s    <= (N+1)'(i_in.count);
            r_t    <= t_eff;
            r_k    <= '0;
            r_bits <= '0;
            r_sym  <= i_in.symbol;
            r_last <= i_in.last;
            r_over <= over_c;
        end else if (i_cmd.mod_step) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_rem <= rem_nx;
            // length search runs alongside the remainder phase
            if (!r_ls_done && !ls_hit) begin
                r_s <= {r_s[N-1:0], 1'b0};
                r_k <= LW'(r_k + 1'b1);
            end
        end else if (i_cmd.exp_step) begin
            r_rem  <= rem_nx;
            r_bits <= {r_bits[CODE_W-2:0], ge};
        end
        if (i_cmd.out_load) begin
            r_out.symbol_out  <= r_sym;
            r_out.code_length <= LEN_W'(len);
            r_out.code_bits   <= r_bits;
            r_out.over_total  <= r_over;
            r_out.last_out    <= r_last;
        end
    end

    assign o_sts.len      = LEN_MAX_W'(len);
    assign o_sts.out_busy = r_valid & i_stall;
    assign o_valid        = r_valid;
    assign o_data         = r_out;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.mod_step || i_cmd.exp_step) |=> (r_rem < RW'(r_den)))
        else $error("remainder not reduced below divisor");

    a_out_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_valid)
        else $error("loaded result not presented");

    a_held_beat_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=> (r_valid && $stable(r_out)))
        else $error("held result beat changed");

endmodule

### rtl/gmc_ctrl.sv
// Controller: sequences remainder, expansion and output load per item.
module gmc_ctrl import gmc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    output t_gmc_cmd o_cmd,
    input  t_gmc_sts i_sts
);

    localparam int N  = COUNT_BITS;
    localparam int CW = $clog2(N + 3);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MOD  = 4'b0010,
        S_EXP  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (r_cnt == CW'(N + 2)) begin
                    n_cnt   = '0;
                    n_state = S_EXP;
                end else begin
                    n_cnt = CW'(r_cnt + 1'b1);
                end
            end
            S_EXP: begin
                o_cmd.exp_step = 1'b1;
                if (CW'(r_cnt + 1'b1) == CW'(i_sts.len)) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = CW'(r_cnt + 1'b1);
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_sts.out_busy)
        else $error("output register overwritten while held");

    a_exp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXP) |-> (r_cnt < CW'(i_sts.len)))
        else $error("expansion ran past code length");

    a_mod_to_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD && r_cnt == CW'(N + 2)) |=> (r_state == S_EXP))
        else $error("remainder phase did not hand over to expansion");

endmodule

### tb/sv/gilbert_moore_code_builder_unit_test.sv
// Self-checking testbench for the Gilbert-Moore code builder unit.
module gilbert_moore_code_builder_unit_test import gmc_pkg::*; ();

    localparam longint unsigned SUM_MAX = (64'd1 << (COUNT_BITS + 1)) - 1;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [COUNT_BITS-1:0] i_cfg_wdata;
    logic                  i_valid;
    logic                  o_stall;
    t_gmc_in               i_in;
    logic                  o_valid;
    logic                  i_stall;
    t_gmc_out              o_data;

    gilbert_moore_code_builder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

    // predictor state: total_count register and running sum of counts
    logic [COUNT_BITS-1:0] total_reg;
    logic [COUNT_BITS:0]   running_sum;

    t_gmc_out pending_codes[$];
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_req;
    int hold_left;
    int mismatches;
    int codes_checked;
    int items_sent;
    int tables_sent;
    int totals_written;
    int idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_gmc_out predict_code(logic [SYM_W-1:0] sym,
                                              logic [COUNT_BITS-1:0] cnt, logic last);
        longint unsigned t, c, cum, k, num, den, rem, bits, sum;
        t_gmc_out r;
        t = total_reg;
        if (t == 0)
            t = 1;
        c = cnt;
        cum = running_sum;
        k = 0;
        while (k < COUNT_BITS && (c << k) < t)
            k++;
        k = k + 1;
        num = 2 * cum + c;
        den = 2 * t;
        rem = num % den;
        bits = 0;
        for (int i = 0; i < k; i++) begin
            rem = rem << 1;
            bits = bits << 1;
            if (rem >= den) begin
                bits = bits | 1;
                rem = rem - den;
            end
        end
        sum = cum + c;
        r.symbol_out  = sym;
        r.code_length = k[LEN_W-1:0];
        r.code_bits   = bits[CODE_W-1:0];
        r.over_total  = (sum > t);
        r.last_out    = last;
        if (sum > SUM_MAX)
            sum = SUM_MAX;
        running_sum = last ? '0 : sum[COUNT_BITS:0];
        return r;
    endfunction

    // receiver: random stalls plus an optional long hold-off
    always @(negedge i_clk) begin
        bit stall_now;
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        stall_now = ($urandom_range(0, 99) < recv_stall_pct);
        if (hold_left > 0) begin
            stall_now = 1'b1;
            hold_left--;
        end
        i_stall <= stall_now;
    end

    // result checker
    always @(posedge i_clk) begin
        t_gmc_out exp_code;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_codes.size() == 0) begin
                $error("unexpected result beat: symbol_out=%0h", o_data.symbol_out);
                mismatches++;
            end else begin
                exp_code = pending_codes.pop_front();
                codes_checked++;
                if (o_data.symbol_out !== exp_code.symbol_out) begin
                    $error("symbol_out expected %0h got %0h",
                           exp_code.symbol_out, o_data.symbol_out);
                    mismatches++;
                end
                if (o_data.code_length !== exp_code.code_length) begin
                    $error("code_length expected %0d got %0d",
                           exp_code.code_length, o_data.code_length);
                    mismatches++;
                end
                if (o_data.code_bits !== exp_code.code_bits) begin
                    $error("code_bits expected %0h got %0h",
                           exp_code.code_bits, o_data.code_bits);
                    mismatches++;
                end
                if (o_data.over_total !== exp_code.over_total) begin
                    $error("over_total expected %0b got %0b",
                           exp_code.over_total, o_data.over_total);
                    mismatches++;
                end
                if (o_data.last_out !== exp_code.last_out) begin
                    $error("last_out expected %0b got %0b",
                           exp_code.last_out, o_data.last_out);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
            $display("gilbert_moore_code_builder_unit_test: FAIL");
            $finish;
        end
    end

    // returns right after the posedge at which the beat is taken
    task automatic send_symbol(logic [SYM_W-1:0] sym, logic [COUNT_BITS-1:0] cnt,
                               logic last);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= '{symbol: sym, count: cnt, last: last};
        do @(posedge i_clk); while (o_stall);
        pending_codes.insert(pending_codes.size(), predict_code(sym, cnt, last));
        items_sent++;
        if (last)
            tables_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (pending_codes.size() == 0);
    endtask

    task automatic set_total(logic [COUNT_BITS-1:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        total_reg = value;
        totals_written++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [COUNT_BITS-1:0] pick_total();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return COUNT_BITS'(1);
            2:       return {COUNT_BITS{1'b1}};
            3, 4, 5: return COUNT_BITS'($urandom_range(2, 255));
            6, 7:    return COUNT_BITS'($urandom_range(256, 65535));
            default: return COUNT_BITS'($urandom);
        endcase
    endfunction

    // well-formed table: counts split the total exactly, last on the final one
    task automatic send_table(int max_syms);
        longint unsigned remaining, c;
        int n;
        remaining = (total_reg == 0) ? 1 : total_reg;
        n = $urandom_range(1, max_syms);
        for (int i = 0; i < n; i++) begin
            if (i == n - 1)
                c = remaining;
            else
                c = 1 + ($urandom % ((remaining / 2 > 0) ? remaining / 2 : 1));
            if (c >= remaining) begin
                send_symbol(SYM_W'($urandom), remaining[COUNT_BITS-1:0], 1'b1);
                return;
            end
            send_symbol(SYM_W'($urandom), c[COUNT_BITS-1:0], 1'b0);
            remaining -= c;
        end
    endtask

    task automatic send_noise();
        logic [COUNT_BITS-1:0] cnt;
        int width;
        width = $urandom_range(0, COUNT_BITS);
        cnt = COUNT_BITS'($urandom);
        cnt = (width == COUNT_BITS) ? cnt : cnt & COUNT_BITS'((1 << width) - 1);
        send_symbol(SYM_W'($urandom), cnt, ($urandom_range(0, 3) == 0));
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // reset total of one: count reaching the total, then zero count
        send_symbol(8'h00, 24'd1, 1'b1);
        send_symbol(8'hFF, 24'd0, 1'b1);
        // widest total: longest code, then an exact fill
        set_total({COUNT_BITS{1'b1}});
        send_symbol(8'h55, 24'd1, 1'b0);
        send_symbol(8'hAA, 24'hFFFFFE, 1'b1);
        // zero total behaves as one; second item overflows
        set_total('0);
        send_symbol(8'h01, 24'd1, 1'b1);
        send_symbol(8'h80, 24'd3, 1'b1);
        set_total(24'd16);
        send_symbol(8'h10, 24'd1, 1'b0);
        send_symbol(8'h20, 24'd2, 1'b0);
        send_symbol(8'h30, 24'd3, 1'b0);
        send_symbol(8'h40, 24'd10, 1'b1);
        send_symbol(8'h41, 24'd8, 1'b0);
        send_symbol(8'h42, 24'd9, 1'b1);
        // running sum saturates and stays over the total
        set_total(24'd5);
        send_symbol(8'h7F, {COUNT_BITS{1'b1}}, 1'b0);
        send_symbol(8'hFE, {COUNT_BITS{1'b1}}, 1'b0);
        send_symbol(8'h01, {COUNT_BITS{1'b1}}, 1'b0);
        send_symbol(8'h02, 24'd1, 1'b1);
        set_total(24'd1000);
        send_symbol(8'h03, 24'd0, 1'b0);
        send_symbol(8'h04, 24'd1000, 1'b1);
        send_symbol(8'h05, 24'h800000, 1'b1);
        drain();
    endtask

    task automatic test_random(int n_items, int sender_pct, int receiver_pct);
        int target;
        int tables;
        target = items_sent + n_items;
        tables = 0;
        send_idle_pct = sender_pct;
        recv_stall_pct = receiver_pct;
        while (items_sent < target) begin
            if (tables % 4 == 0)
                set_total(pick_total());
            if ($urandom_range(0, 99) < 15) begin
                repeat ($urandom_range(1, 3))
                    send_noise();
            end else begin
                send_table(12);
            end
            tables++;
        end
        drain();
    endtask

    task automatic test_backpressure();
        set_total(24'd200);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b1;
        repeat (3)
            send_table(10);
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_valid = 1'b0;
        i_in = '0;
        i_stall = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatches = 0;
        codes_checked = 0;
        items_sent = 0;
        tables_sent = 0;
        totals_written = 0;
        idle_cycles = 0;
        total_reg = 1;
        running_sum = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(530, 22, 57);
        test_random(530, 57, 22);
        test_backpressure();
        test_random(530, 0, 0);

        drain();
        repeat (80) @(posedge i_clk);
        $display("covered %0d symbol beats in %0d closed tables over %0d total_count writes",
                 items_sent, tables_sent, totals_written);
        $display("checked %0d code words, %0d mismatches", codes_checked, mismatches);
        if (mismatches == 0)
            $display("gilbert_moore_code_builder_unit_test: PASS");
        else
            $display("gilbert_moore_code_builder_unit_test: FAIL");
        $finish;
    end

endmodule
